// ===== sv/segi_pkg.sv =====
// Shared types, widths and the divider step for the segment intersection block.
package segi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int NUM_W      = CROSS_W + FRAC_BITS;
  localparam int SPARAM_W   = 24;
  localparam int QUO_W      = SPARAM_W;
  localparam int PT_W       = 32;
  localparam int QS_W       = FRAC_BITS + 2;
  localparam int PX_W       = QS_W + DIFF_W;
  localparam int SUM_W      = PT_W + 4;
  localparam int OVF_SH     = QUO_W - FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] m_x;
    logic signed [COORD_BITS-1:0] m_y;
    logic signed [COORD_BITS-1:0] n_x;
    logic signed [COORD_BITS-1:0] n_y;
    logic signed [COORD_BITS-1:0] u_x;
    logic signed [COORD_BITS-1:0] u_y;
    logic signed [COORD_BITS-1:0] v_x;
    logic signed [COORD_BITS-1:0] v_y;
  } in_t;

  typedef struct packed {
    logic                       hit;
    logic                       is_parallel;
    logic signed [SPARAM_W-1:0] s_param;
    logic signed [PT_W-1:0]     hit_x;
    logic signed [PT_W-1:0]     hit_y;
  } out_t;

  // sideband that rides along the divider
  typedef struct packed {
    logic                         par;
    logic                         hit;
    logic                         neg;
    logic                         ovf;
    logic signed [COORD_BITS-1:0] m_x;
    logic signed [COORD_BITS-1:0] m_y;
    logic signed [DIFF_W-1:0]     r_x;
    logic signed [DIFF_W-1:0]     r_y;
  } side_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [CROSS_W:0] div_step(input logic [CROSS_W-1:0] rem,
                                                input logic               b,
                                                input logic [CROSS_W-1:0] den);
    logic [CROSS_W:0] t;
    logic [CROSS_W:0] d;
    logic [CROSS_W:0] diff;
    t    = {rem, b};
    d    = {1'b0, den};
    diff = t - d;
    if (t >= d) begin
      div_step = {1'b1, diff[CROSS_W-1:0]};
    end else begin
      div_step = {1'b0, t[CROSS_W-1:0]};
    end
  endfunction

endpackage

// ===== sv/segment_intersection.sv =====
// Top level of the 2D segment intersection pipeline.
//
// Takes one pair of segments m-n and u-v per clock while in_stall is low and
// returns one item per input: hit, is_parallel, s (Q7.16, saturated) and the
// hit point (Q15.16). Throughput is one item every cycle unless stalled. The
// stages are four front stages (differences, products, cross products, sign
// fold and range tests), 24 stages of the pipelined divider that forms s one
// quotient bit per stage, then one stage for the point multiply and one for
// the add and saturate, which is also the output register. Every stage holds
// its item when the next one is full, so bubbles close up and a stalled output still
// lets new items in until the pipeline is full.
module segment_intersection (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  segi_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output segi_pkg::out_t  out_data
);
  import segi_pkg::*;

  // ---- stage 1: edge vectors r = n-m, q = v-u, w = u-m
  typedef struct packed {
    logic signed [COORD_BITS-1:0] m_x, m_y;
    logic signed [DIFF_W-1:0]     r_x, r_y, q_x, q_y, w_x, w_y;
  } s1_t;

  // ---- stage 2: the six partial products
  typedef struct packed {
    logic signed [COORD_BITS-1:0] m_x, m_y;
    logic signed [DIFF_W-1:0]     r_x, r_y;
    logic signed [PROD_W-1:0]     p0, p1, p2, p3, p4, p5;
  } s2_t;

  // ---- stage 3: den, tnum, snum
  typedef struct packed {
    logic signed [COORD_BITS-1:0] m_x, m_y;
    logic signed [DIFF_W-1:0]     r_x, r_y;
    logic signed [CROSS_W-1:0]    den, tn, sn;
  } s3_t;

  // ---- post-divider stage: saturated s and products qs*r
  typedef struct packed {
    logic                         par;
    logic                         hit;
    logic signed [SPARAM_W-1:0]   s;
    logic signed [COORD_BITS-1:0] m_x, m_y;
    logic signed [PX_W-1:0]       px, py;
  } sa_t;

  logic  v1_r, v2_r, v3_r, v4_r, va_r, vb_r;
  logic  rdy1, rdy2, rdy3, rdy4, rdya, rdyb;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  s3_t   s3_r, s3_nxt;
  sa_t   sa_r, sa_nxt;
  out_t  ob_r, ob_nxt;

  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [CROSS_W-1:0] dden_r, dden_nxt;
  side_t              side_r, side_nxt;

  logic               div_in_stall, div_out_valid;
  logic [QUO_W-1:0]   div_quo;
  side_t              div_side;

  // ---- ready chain: a stage takes a new item when empty or draining
  assign rdyb = !vb_r || !out_stall;
  assign rdya = !va_r || rdyb;
  assign rdy4 = !v4_r || !div_in_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // ---- stage 1
  always_comb begin
    s1_nxt.m_x = in_data.m_x;
    s1_nxt.m_y = in_data.m_y;
    s1_nxt.r_x = {in_data.n_x[COORD_BITS-1], in_data.n_x}
               - {in_data.m_x[COORD_BITS-1], in_data.m_x};
    s1_nxt.r_y = {in_data.n_y[COORD_BITS-1], in_data.n_y}
               - {in_data.m_y[COORD_BITS-1], in_data.m_y};
    s1_nxt.q_x = {in_data.v_x[COORD_BITS-1], in_data.v_x}
               - {in_data.u_x[COORD_BITS-1], in_data.u_x};
    s1_nxt.q_y = {in_data.v_y[COORD_BITS-1], in_data.v_y}
               - {in_data.u_y[COORD_BITS-1], in_data.u_y};
    s1_nxt.w_x = {in_data.u_x[COORD_BITS-1], in_data.u_x}
               - {in_data.m_x[COORD_BITS-1], in_data.m_x};
    s1_nxt.w_y = {in_data.u_y[COORD_BITS-1], in_data.u_y}
               - {in_data.m_y[COORD_BITS-1], in_data.m_y};
  end

  // ---- stage 2: den = qx*ry - qy*rx, tn = rx*wy - ry*wx, sn = qx*wy - qy*wx
  always_comb begin
    s2_nxt.m_x = s1_r.m_x;
    s2_nxt.m_y = s1_r.m_y;
    s2_nxt.r_x = s1_r.r_x;
    s2_nxt.r_y = s1_r.r_y;
    s2_nxt.p0  = s1_r.q_x * s1_r.r_y;
    s2_nxt.p1  = s1_r.q_y * s1_r.r_x;
    s2_nxt.p2  = s1_r.r_x * s1_r.w_y;
    s2_nxt.p3  = s1_r.r_y * s1_r.w_x;
    s2_nxt.p4  = s1_r.q_x * s1_r.w_y;
    s2_nxt.p5  = s1_r.q_y * s1_r.w_x;
  end

  // ---- stage 3
  always_comb begin
    s3_nxt.m_x = s2_r.m_x;
    s3_nxt.m_y = s2_r.m_y;
    s3_nxt.r_x = s2_r.r_x;
    s3_nxt.r_y = s2_r.r_y;
    s3_nxt.den = {s2_r.p0[PROD_W-1], s2_r.p0} - {s2_r.p1[PROD_W-1], s2_r.p1};
    s3_nxt.tn  = {s2_r.p2[PROD_W-1], s2_r.p2} - {s2_r.p3[PROD_W-1], s2_r.p3};
    s3_nxt.sn  = {s2_r.p4[PROD_W-1], s2_r.p4} - {s2_r.p5[PROD_W-1], s2_r.p5};
  end

  // ---- stage 4: fold sign into den, range tests, divider operands
  logic signed [CROSS_W-1:0] dn, tnf, snf;
  logic        [CROSS_W-1:0] smag;
  always_comb begin
    dn   = s3_r.den[CROSS_W-1] ? -s3_r.den : s3_r.den;
    tnf  = s3_r.den[CROSS_W-1] ? -s3_r.tn  : s3_r.tn;
    snf  = s3_r.den[CROSS_W-1] ? -s3_r.sn  : s3_r.sn;
    smag = snf[CROSS_W-1] ? CROSS_W'(-snf) : CROSS_W'(snf);

    side_nxt.par = (s3_r.den == '0);
    side_nxt.hit = !tnf[CROSS_W-1] && (tnf <= dn) && !snf[CROSS_W-1] && (snf <= dn);
    side_nxt.neg = snf[CROSS_W-1];
    // quotient would need more than QUO_W bits
    side_nxt.ovf = {{OVF_SH{1'b0}}, smag} >= {dn, {OVF_SH{1'b0}}};
    side_nxt.m_x = s3_r.m_x;
    side_nxt.m_y = s3_r.m_y;
    side_nxt.r_x = s3_r.r_x;
    side_nxt.r_y = s3_r.r_y;
    num_nxt      = {smag, {FRAC_BITS{1'b0}}};
    dden_nxt     = dn;
  end

  segi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_stall  (div_in_stall),
    .in_num    (num_r),
    .in_den    (dden_r),
    .in_side   (side_r),
    .out_valid (div_out_valid),
    .out_stall (!rdya),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // ---- stage A: saturate s, form qs*r (qs <= 1.0 whenever hit)
  localparam logic [QUO_W-1:0] S_POS_MAX = QUO_W'((1 << (SPARAM_W - 1)) - 1);
  localparam logic [QUO_W-1:0] S_NEG_MAG = QUO_W'(1 << (SPARAM_W - 1));

  logic signed [QS_W-1:0] qs;
  always_comb begin
    qs         = $signed({1'b0, div_quo[FRAC_BITS:0]});
    sa_nxt.par = div_side.par;
    sa_nxt.hit = div_side.hit && !div_side.par;
    sa_nxt.m_x = div_side.m_x;
    sa_nxt.m_y = div_side.m_y;
    sa_nxt.px  = qs * div_side.r_x;
    sa_nxt.py  = qs * div_side.r_y;
    if (div_side.par) begin
      sa_nxt.s = '0;
    end else if (div_side.neg) begin
      if (div_side.ovf || div_quo > S_NEG_MAG) begin
        sa_nxt.s = $signed(-S_NEG_MAG);
      end else begin
        sa_nxt.s = $signed(-div_quo);
      end
    end else begin
      if (div_side.ovf || div_quo > S_POS_MAX) begin
        sa_nxt.s = $signed(S_POS_MAX);
      end else begin
        sa_nxt.s = $signed(div_quo);
      end
    end
  end

  // ---- stage B: p = m*2^F + qs*r, saturated to 32 bits
  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (PT_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      sat_pt = PT_W'(hi);
    end else if (v < lo) begin
      sat_pt = PT_W'(lo);
    end else begin
      sat_pt = PT_W'(v);
    end
  endfunction

  logic signed [SUM_W-1:0] sum_x, sum_y;
  always_comb begin
    sum_x = SUM_W'(sa_r.m_x) * SUM_W'(1 << FRAC_BITS) + SUM_W'(sa_r.px);
    sum_y = SUM_W'(sa_r.m_y) * SUM_W'(1 << FRAC_BITS) + SUM_W'(sa_r.py);
    ob_nxt.hit         = sa_r.hit;
    ob_nxt.is_parallel = sa_r.par;
    ob_nxt.s_param     = sa_r.s;
    ob_nxt.hit_x       = sa_r.hit ? sat_pt(sum_x) : '0;
    ob_nxt.hit_y       = sa_r.hit ? sat_pt(sum_y) : '0;
  end

  // ---- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdya) va_r <= div_out_valid;
      if (rdyb) vb_r <= va_r;
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
    if (rdy4) begin
      num_r  <= num_nxt;
      dden_r <= dden_nxt;
      side_r <= side_nxt;
    end
    if (rdya) sa_r <= sa_nxt;
    if (rdyb) ob_r <= ob_nxt;
  end

  assign out_valid = vb_r;
  assign out_data  = ob_r;

`ifndef SYNTHESIS
  // input held off only when the pipeline is backed up to the output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  a_hit_not_par: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.is_parallel))
    else $error("hit reported on parallel segments");

  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_parallel) |->
      (out_data.s_param == '0 && out_data.hit_x == '0 && out_data.hit_y == '0))
    else $error("parallel item carries nonzero fields");

  a_hit_s_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |->
      (!out_data.s_param[SPARAM_W-1] &&
       out_data.s_param <= $signed(SPARAM_W'(1 << FRAC_BITS))))
    else $error("hit with s outside 0..1");
`endif

endmodule

// ===== sv/segi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module segi_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [segi_pkg::NUM_W-1:0]      in_num,
  input  logic [segi_pkg::CROSS_W-1:0]    in_den,
  input  segi_pkg::side_t                 in_side,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [segi_pkg::QUO_W-1:0]      out_quo,
  output segi_pkg::side_t                 out_side
);
  import segi_pkg::*;

  localparam int N = QUO_W;

  logic                 v_r    [1:N];
  logic [CROSS_W-1:0]   rem_r  [1:N];
  logic [QUO_W-1:0]     q_r    [1:N];
  logic [NUM_W-1:0]     num_r  [1:N];
  logic [CROSS_W-1:0]   den_r  [1:N];
  side_t                side_r [1:N];
  logic                 ready  [1:N+1];

  assign ready[N+1] = !out_stall;

  for (genvar j = 1; j <= N; j++) begin : g_st
    logic               pv;
    logic [CROSS_W-1:0] prem;
    logic [QUO_W-1:0]   pq;
    logic [NUM_W-1:0]   pnum;
    logic [CROSS_W-1:0] pden;
    side_t              pside;
    logic [CROSS_W:0]   step;

    if (j == 1) begin : g_head
      // stage 0 is the input port itself (not registered)
      assign pv    = in_valid;
      assign prem  = CROSS_W'(in_num[NUM_W-1:QUO_W]);
      assign pq    = '0;
      assign pnum  = in_num;
      assign pden  = in_den;
      assign pside = in_side;
    end else begin : g_body
      assign pv    = v_r[j-1];
      assign prem  = rem_r[j-1];
      assign pq    = q_r[j-1];
      assign pnum  = num_r[j-1];
      assign pden  = den_r[j-1];
      assign pside = side_r[j-1];
    end

    assign ready[j] = !v_r[j] || ready[j+1];
    assign step = div_step(prem, pnum[N-j], pden);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (ready[j]) begin
        v_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (ready[j]) begin
        rem_r[j]  <= step[CROSS_W-1:0];
        q_r[j]    <= {pq[QUO_W-2:0], step[CROSS_W]};
        num_r[j]  <= pnum;
        den_r[j]  <= pden;
        side_r[j] <= pside;
      end
    end
  end

  assign in_stall  = !ready[1];
  assign out_valid = v_r[N];
  assign out_quo   = q_r[N];
  assign out_side  = side_r[N];

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the segment intersection pipeline.
`timescale 1ns / 100ps

module tb_top;
  import segi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int N_RANDOM    = 450;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  segment_intersection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  out_t pending_q[$];
  int   n_err;
  int   n_seen;
  int   n_hits;
  int   n_par;
  int   n_miss;
  int   cycles;
  bit   calm;        // no idling on either side
  bit   long_hold;   // receiver holds off for a long stretch

  function automatic logic [31:0] clamp32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'h7fffffff;
    if (x < -128'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  // Exact integer crossing test and fixed point s / hit point.
  function automatic out_t predict_crossing(input in_t a);
    logic signed [127:0] mx, my, rx, ry, qx, qy, wx, wy;
    logic signed [127:0] den, tn, sn, num, quo, sv;
    out_t o;
    mx = a.m_x; my = a.m_y;
    rx = 128'(a.n_x) - mx; ry = 128'(a.n_y) - my;
    qx = 128'(a.v_x) - 128'(a.u_x); qy = 128'(a.v_y) - 128'(a.u_y);
    wx = 128'(a.u_x) - mx; wy = 128'(a.u_y) - my;
    den = qx * ry - qy * rx;
    tn  = rx * wy - ry * wx;
    sn  = qx * wy - qy * wx;
    o = '0;
    if (den == 0) begin
      o.is_parallel = 1'b1;
      return o;
    end
    if (den < 0) begin
      den = -den; tn = -tn; sn = -sn;
    end
    num = (sn < 0) ? -sn : sn;
    num = num <<< FRAC_BITS;
    quo = num / den;
    if (sn < 0) begin
      sv = (quo > 128'sd8388608) ? 128'sd8388608 : quo;
      sv = -sv;
    end else begin
      sv = (quo > 128'sd8388607) ? 128'sd8388607 : quo;
    end
    o.s_param = sv[SPARAM_W-1:0];
    if (tn >= 0 && tn <= den && sn >= 0 && sn <= den) begin
      o.hit   = 1'b1;
      o.hit_x = clamp32((mx <<< FRAC_BITS) + quo * rx);
      o.hit_y = clamp32((my <<< FRAC_BITS) + quo * ry);
    end
    return o;
  endfunction

  // Directed table: typed expectation only where it is obvious.
  typedef struct {
    in_t  d;
    bit   typed;
    out_t e;
  } row_t;

  function automatic in_t seg(input int mx, my, nx, ny, ux, uy, vx, vy);
    in_t s;
    s.m_x = COORD_BITS'(mx); s.m_y = COORD_BITS'(my);
    s.n_x = COORD_BITS'(nx); s.n_y = COORD_BITS'(ny);
    s.u_x = COORD_BITS'(ux); s.u_y = COORD_BITS'(uy);
    s.v_x = COORD_BITS'(vx); s.v_y = COORD_BITS'(vy);
    return s;
  endfunction

  row_t dir_rows[$];

  function automatic void add_row(input in_t d, input bit typed, input out_t e);
    row_t r;
    r.d = d; r.typed = typed; r.e = e;
    dir_rows.push_back(r);
  endfunction

  function automatic in_t rand_item();
    in_t s;
    int  cx, cy, ax, ay, bx, by, k, lim;
    k = $urandom_range(0, 99);
    if (k < 20) begin
      s = in_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (k < 30) begin
      // tiny coordinates: endpoint touches and collinear cases are common
      s = seg($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
              $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
              $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
              $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
    end else if (k < 40) begin
      // parallel: same direction vector on both segments
      ax = $urandom_range(0, 20000) - 10000; ay = $urandom_range(0, 20000) - 10000;
      cx = $urandom_range(0, 20000) - 10000; cy = $urandom_range(0, 20000) - 10000;
      bx = $urandom_range(0, 20000) - 10000; by = $urandom_range(0, 20000) - 10000;
      s = seg(cx, cy, cx + ax, cy + ay, bx, by, bx + ax, by + ay);
    end else begin
      // crossing pairs around a center, some shortened so they miss
      lim = ($urandom_range(0, 3) == 0) ? 16000 : 300;
      cx = $urandom_range(0, 32000) - 16000; cy = $urandom_range(0, 32000) - 16000;
      ax = $urandom_range(0, 2 * lim) - lim; ay = $urandom_range(0, 2 * lim) - lim;
      bx = $urandom_range(0, 2 * lim) - lim; by = $urandom_range(0, 2 * lim) - lim;
      if (k < 75) begin
        s = seg(cx + ax, cy + ay, cx - ax, cy - ay, cx + bx, cy + by, cx - bx, cy - by);
      end else begin
        s = seg(cx + ax, cy + ay, cx + ax / 3, cy + ay / 3,
                cx + bx, cy + by, cx - bx / 2, cy - by / 2);
      end
    end
    return s;
  endfunction

  task automatic offer(input in_t d, input bit typed, input out_t e);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(typed ? e : predict_crossing(d));
    @(negedge clk);
  endtask

  // Receiver stall pattern.
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      w = calm ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        n_err++;
      end else begin
        x = pending_q.pop_front();
        n_seen++;
        if (x.hit) n_hits++;
        else if (x.is_parallel) n_par++;
        else n_miss++;
        if (out_data.hit !== x.hit) begin
          $error("hit: expected %0d actual %0d", x.hit, out_data.hit); n_err++;
        end
        if (out_data.is_parallel !== x.is_parallel) begin
          $error("is_parallel: expected %0d actual %0d", x.is_parallel,
                 out_data.is_parallel); n_err++;
        end
        if (out_data.s_param !== x.s_param) begin
          $error("s_param: expected %0d actual %0d", x.s_param, out_data.s_param);
          n_err++;
        end
        if (out_data.hit_x !== x.hit_x) begin
          $error("hit_x: expected %0d actual %0d", x.hit_x, out_data.hit_x); n_err++;
        end
        if (out_data.hit_y !== x.hit_y) begin
          $error("hit_y: expected %0d actual %0d", x.hit_y, out_data.hit_y); n_err++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_intersection regression: fail");
      $finish;
    end
  end

  initial begin
    out_t par_e, diag_e, none;
    n_err = 0; n_seen = 0; n_hits = 0; n_par = 0; n_miss = 0; cycles = 0;
    calm = 1'b0; long_hold = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    none = '0;
    par_e = '0; par_e.is_parallel = 1'b1;
    diag_e = '0; diag_e.hit = 1'b1; diag_e.s_param = 24'sd32768;
    diag_e.hit_x = -32'sd32768; diag_e.hit_y = -32'sd32768;

    add_row(seg(0, 0, 0, 0, 0, 0, 0, 0), 1, par_e);                     // all points
    add_row(seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1, diag_e);
    add_row(seg(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768), 1, par_e);
    add_row(seg(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 0, none);    // full axes
    add_row(seg(0, 0, 10, 0, 0, 0, 0, 10), 0, none);                   // touch at starts
    add_row(seg(0, 0, 10, 0, 10, -5, 10, 5), 0, none);                 // s exactly one
    add_row(seg(0, 0, 10, 0, 5, 0, 5, 7), 0, none);                    // t exactly zero
    add_row(seg(0, 0, 10, 0, 5, -7, 5, 0), 0, none);                   // t exactly one
    add_row(seg(0, 0, 10, 0, 11, -5, 11, 5), 0, none);                 // s just past one
    add_row(seg(0, 0, 1, 0, 30000, -5, 30000, 5), 0, none);            // s saturates high
    add_row(seg(0, 0, 1, 0, -30000, -5, -30000, 5), 0, none);          // s saturates low
    add_row(seg(0, 0, 10, 0, 5, 5, 5, -5), 0, none);                   // positive den
    add_row(seg(0, 0, 10, 10, 2, 2, 20, 20), 0, none);                 // collinear overlap
    add_row(seg(3, 3, 3, 3, 0, 0, 5, 9), 0, none);                     // first is a point
    add_row(seg(0, 0, 3, 1, 1, 0, 0, 1), 0, none);                     // s of one quarter
    add_row(seg(-1, -1, -32768, 32767, 32767, -32768, -2, 5), 0, none);
    add_row(seg(0, 0, 10, 0, 5, 1, 5, 9), 0, none);                    // t below zero

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].d, dir_rows[i].typed, dir_rows[i].e);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 150 && i < 220);
      if (i == 100) long_hold = 1'b1;           // fill the pipe behind a held output
      if (i == 300) begin
        in_valid <= 1'b0;                       // sender drains everything first
        wait (pending_q.size() == 0);
        @(negedge clk);
      end
      offer(rand_item(), 0, none);
    end
    in_valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d results: %0d crossings, %0d parallel, %0d misses",
             n_seen, n_hits, n_par, n_miss);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("segment_intersection regression: pass");
    end else begin
      $display("segment_intersection regression: fail");
    end
    $finish;
  end

endmodule
